### rtl/core/cxr_pkg.sv
// ----------------------------------------------------------------------------
// cxr_pkg
// Shared types, constants and coefficient helpers for the CIE xy to RGB
// converter.
// ----------------------------------------------------------------------------
package cxr_pkg;

  localparam int     CXR_COEF_FRAC_BITS = 20;
  localparam int     CXR_STAGES         = 12;
  localparam int     CXR_DIV_STAGES     = 8;
  localparam longint MICRO_SCALE        = 1000000;

  typedef struct packed {
    logic [15:0] x_coord;
    logic [15:0] y_coord;
  } cxr_req_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cxr_res_t;

  // srgb (d65) matrix in millionths, rows red/green/blue, columns x/y/z
  function automatic longint cxr_coef_micro(int row, int col);
    longint val;
    case (row * 3 + col)
      0:       val = 3240479;
      1:       val = -1537150;
      2:       val = -498535;
      3:       val = -969256;
      4:       val = 1875992;
      5:       val = 41556;
      6:       val = 55648;
      7:       val = -204043;
      8:       val = 1057311;
      default: val = 0;
    endcase
    return val;
  endfunction

  // round to nearest, half away from zero
  function automatic longint cxr_coef(int row, int col, int frac_bits);
    longint micro;
    longint mag;
    longint q;
    micro = cxr_coef_micro(row, col);
    mag   = (micro < 0) ? -micro : micro;
    q     = ((mag << frac_bits) + MICRO_SCALE / 2) / MICRO_SCALE;
    return (micro < 0) ? -q : q;
  endfunction

endpackage

### rtl/core/cxr_channel.sv
// ----------------------------------------------------------------------------
// cxr_channel
// One color channel: matrix row products, sum, range check and an eight
// stage restoring divider giving the rounded 8-bit level.
// ----------------------------------------------------------------------------
module cxr_channel #(
  parameter int FracBits = cxr_pkg::CXR_COEF_FRAC_BITS,
  parameter int Row      = 0
) (
  input  logic                           clk,
  input  logic [cxr_pkg::CXR_STAGES-1:1] en,
  input  logic [15:0]                    x_coord,
  input  logic [15:0]                    y_coord,
  input  logic [15:0]                    z_coord,
  output logic [7:0]                     level
);
  import cxr_pkg::*;

  localparam int CoefW   = FracBits + 3;
  localparam int PW      = FracBits + 20;
  localparam int NW      = FracBits + 22;
  localparam int DW      = FracBits + 16;
  localparam int MW      = DW + 9;
  localparam int DivBase = CXR_STAGES - CXR_DIV_STAGES;

  localparam logic signed [CoefW-1:0] CoefX = CoefW'(cxr_coef(Row, 0, FracBits));
  localparam logic signed [CoefW-1:0] CoefY = CoefW'(cxr_coef(Row, 1, FracBits));
  localparam logic signed [CoefW-1:0] CoefZ = CoefW'(cxr_coef(Row, 2, FracBits));

  typedef struct packed {
    logic neg;
    logic sat;
  } ch_flags_t;

  logic signed [16:0]   xs;
  logic signed [16:0]   ys;
  logic signed [16:0]   zs;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [PW-1:0] pz;
  logic [15:0]          y1;
  logic signed [NW-1:0] n2;
  logic [DW-1:0]        d2;
  logic                 pos;
  logic                 neg;
  logic                 sat;
  logic [MW-1:0]        nlo;
  logic [MW-1:0]        m;

  logic [MW-1:0]  rem [0:CXR_DIV_STAGES-1];
  logic [DW-1:0]  den [0:CXR_DIV_STAGES-1];
  logic [7:0]     q   [0:CXR_DIV_STAGES-1];
  ch_flags_t      flg [0:CXR_DIV_STAGES-1];

  assign xs = $signed({1'b0, x_coord});
  assign ys = $signed({1'b0, y_coord});
  assign zs = $signed({1'b0, z_coord});

  // products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      px <= PW'(CoefX) * PW'(xs);
      py <= PW'(CoefY) * PW'(ys);
      pz <= PW'(CoefZ) * PW'(zs);
      y1 <= y_coord;
    end
  end

  // numerator and denominator
  always_ff @(posedge clk) begin
    if (en[2]) begin
      n2 <= NW'(px) + NW'(py) + NW'(pz);
      d2 <= {y1, {FracBits{1'b0}}};
    end
  end

  // range check and scaled dividend 510*n + d
  always_comb begin
    pos = !n2[NW-1] && (n2 != '0);
    neg = !pos;
    sat = pos && ($unsigned(n2) >= NW'(d2));
    nlo = MW'(n2[DW-1:0]);
    m   = (nlo << 9) - (nlo << 1) + MW'(d2);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rem[0]     <= m;
      den[0]     <= d2;
      q[0]       <= '0;
      flg[0].neg <= neg;
      flg[0].sat <= sat;
    end
  end

  // one quotient bit per stage against divisor 2*d
  for (genvar k = 0; k < CXR_DIV_STAGES; k++) begin : g_div
    localparam int Bit = CXR_DIV_STAGES - 1 - k;
    logic [MW-1:0] trial;
    logic          take;
    logic [7:0]    q_next;

    assign trial  = MW'({den[k], 1'b0}) << Bit;
    assign take   = rem[k] >= trial;
    assign q_next = q[k] | ({7'b0, take} << Bit);

    if (k < CXR_DIV_STAGES - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en[DivBase + k]) begin
          rem[k+1] <= take ? (rem[k] - trial) : rem[k];
          den[k+1] <= den[k];
          flg[k+1] <= flg[k];
          q[k+1]   <= q_next;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en[DivBase + k]) begin
          if (flg[k].neg) begin
            level <= 8'h00;
          end else if (flg[k].sat) begin
            level <= 8'hFF;
          end else begin
            level <= q_next;
          end
        end
      end
    end
  end

endmodule

### rtl/core/cie_xy_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// cie_xy_to_rgb_converter
// Converts a CIE xy chromaticity pair to clamped, rounded 8-bit sRGB.
// ----------------------------------------------------------------------------
// Usage:
//   A request (x_coord, y_coord, 65535 = 1.0) is taken on an edge where
//   req_valid is high and req_stall is low. Each request gives exactly one
//   result on res, held under res_stall until taken.
//   valid_res is low, with all colors zero, when y is zero or x+y > 65535.
//   Throughput: one request per cycle while req_stall is low; the pipeline is twelve register
//   stages, eight of them the one-bit-per-stage restoring divider that
//   forms numerator/y for all three channels in parallel.
//   Reset clears every stage valid bit; payload registers are not reset.
//   Under res_stall the pipeline keeps moving until its empty slots are
//   filled; req_stall rises only once every stage holds a request.
// ----------------------------------------------------------------------------
module cie_xy_to_rgb_converter #(
  parameter int COEF_FRAC_BITS = cxr_pkg::CXR_COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  cxr_pkg::cxr_req_t req,
  output logic              res_valid,
  input  logic              res_stall,
  output cxr_pkg::cxr_res_t res
);
  import cxr_pkg::*;

  localparam int Last = CXR_STAGES - 1;

  logic [CXR_STAGES-1:0] vld;
  logic [CXR_STAGES-1:0] ready;
  logic [CXR_STAGES-1:0] ok_pipe;
  logic [16:0]           sum;
  logic                  ok;
  logic [15:0]           x0;
  logic [15:0]           y0;
  logic [15:0]           z0;
  logic [7:0]            red_lvl;
  logic [7:0]            green_lvl;
  logic [7:0]            blue_lvl;

  // a stage can load when empty or when its content moves on
  for (genvar k = 0; k < CXR_STAGES; k++) begin : g_ready
    if (k == Last) begin : g_out
      assign ready[k] = !vld[k] || !res_stall;
    end else begin : g_mid
      assign ready[k] = !vld[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < CXR_STAGES; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // input check; rejected pairs run through as zeros
  always_comb begin
    sum = {1'b0, req.x_coord} + {1'b0, req.y_coord};
    ok  = (req.y_coord != '0) && !sum[16];
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      ok_pipe[0] <= ok;
      x0         <= ok ? req.x_coord : '0;
      y0         <= ok ? req.y_coord : '0;
      z0         <= ok ? (16'hFFFF - sum[15:0]) : '0;
    end
    for (int k = 1; k < CXR_STAGES; k++) begin
      if (ready[k]) begin
        ok_pipe[k] <= ok_pipe[k-1];
      end
    end
  end

  cxr_channel #(.FracBits(COEF_FRAC_BITS), .Row(0)) u_red (
    .clk     (clk),
    .en      (ready[CXR_STAGES-1:1]),
    .x_coord (x0),
    .y_coord (y0),
    .z_coord (z0),
    .level   (red_lvl)
  );

  cxr_channel #(.FracBits(COEF_FRAC_BITS), .Row(1)) u_green (
    .clk     (clk),
    .en      (ready[CXR_STAGES-1:1]),
    .x_coord (x0),
    .y_coord (y0),
    .z_coord (z0),
    .level   (green_lvl)
  );

  cxr_channel #(.FracBits(COEF_FRAC_BITS), .Row(2)) u_blue (
    .clk     (clk),
    .en      (ready[CXR_STAGES-1:1]),
    .x_coord (x0),
    .y_coord (y0),
    .z_coord (z0),
    .level   (blue_lvl)
  );

  assign req_stall     = !ready[0];
  assign res_valid     = vld[Last];
  assign res.valid_res = ok_pipe[Last];
  assign res.red       = red_lvl;
  assign res.green     = green_lvl;
  assign res.blue      = blue_lvl;

  a_reject_black: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.valid_res |-> res.red == 8'h00 && res.green == 8'h00
                                    && res.blue == 8'h00)
    else $error("rejected pair gives nonzero color");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> vld[0])
    else $error("accepted request missing from first stage");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> !req_stall)
    else $error("request stalled with first stage empty");

endmodule
